// ===== sv/slcp_pkg.sv =====
// Shared constants and types for the serial LED command parser.
package slcp_pkg;

   localparam int LINE_BYTES = 64;
   localparam int LEN_W      = $clog2(LINE_BYTES);
   localparam int NUM_KEYS   = 7;
   localparam int VAL_W      = 10;
   localparam int POS_W      = 3;

   localparam logic [VAL_W-1:0] LED_COUNT_RESET = 10'd150;
   localparam logic [VAL_W-1:0] STEP_RESET      = 10'd1;

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_Z       = 8'h7A;

   // Key slots, in the order the trackers are instantiated.
   localparam int KEY_MODE  = 0;
   localparam int KEY_RED   = 1;
   localparam int KEY_GREEN = 2;
   localparam int KEY_BLUE  = 3;
   localparam int KEY_FIRST = 4;
   localparam int KEY_LAST  = 5;
   localparam int KEY_STEP  = 6;

   // Window limits: one skipped byte plus the digit places.
   localparam logic [POS_W-1:0] WINDOW_ONE   = 3'd2;
   localparam logic [POS_W-1:0] WINDOW_THREE = 3'd4;

   function automatic logic [7:0] key_char(input int idx);
      logic [7:0] code;
      case (idx)
         KEY_MODE:  code = 8'h6D;  // m
         KEY_RED:   code = 8'h72;  // r
         KEY_GREEN: code = 8'h67;  // g
         KEY_BLUE:  code = 8'h62;  // b
         KEY_FIRST: code = 8'h66;  // f
         KEY_LAST:  code = 8'h6C;  // l
         default:   code = 8'h69;  // i
      endcase
      return code;
   endfunction

   typedef struct packed {
      logic scan;
      logic clear;
   } slcp_ctrl_type;

   typedef struct packed {
      logic [3:0]       mode;
      logic [7:0]       red;
      logic [7:0]       green;
      logic [7:0]       blue;
      logic [VAL_W-1:0] first_led;
      logic [VAL_W-1:0] last_led;
      logic [VAL_W-1:0] led_step;
   } slcp_cmd_type;

endpackage

// ===== sv/slcp_key_track.sv =====
// Per-key tracker: first-appearance detection, read window and decimal accumulator.
module slcp_key_track
   import slcp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  slcp_ctrl_type       ctrl,
   input  logic [7:0]          rx_byte,
   input  logic [7:0]          key_code,
   input  logic [POS_W-1:0]    window_lim,
   output logic                seen,
   output logic [VAL_W-1:0]    acc
);

   logic             seen_ff, seen_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [VAL_W-1:0] acc_ff, acc_in;
   logic             is_digit;
   logic [VAL_W-1:0] times_ten;

   assign is_digit  = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
   assign times_ten = (acc_ff << 3) + (acc_ff << 1);

   always_comb begin
      seen_in = seen_ff;
      pos_in  = pos_ff;
      acc_in  = acc_ff;
      if (ctrl.clear) begin
         seen_in = 1'b0;
         pos_in  = '0;
         acc_in  = '0;
      end else if (ctrl.scan) begin
         if (seen_ff) begin
            if (pos_ff < window_lim) begin
               pos_in = pos_ff + POS_W'(1);
               // The byte right after the key is skipped; digits count from place two.
               if ((pos_ff != '0) && is_digit) begin
                  acc_in = times_ten + VAL_W'(rx_byte[3:0]);
               end
            end
         end else if (rx_byte == key_code) begin
            seen_in = 1'b1;
            pos_in  = '0;
            acc_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
         pos_ff  <= '0;
         acc_ff  <= '0;
      end else begin
         seen_ff <= seen_in;
         pos_ff  <= pos_in;
         acc_ff  <= acc_in;
      end
   end

   assign seen = seen_ff;
   assign acc  = acc_ff;

endmodule

// ===== sv/slcp_line_ctrl.sv =====
// Line framing, zero-byte cut, 'z' detection and the kept command values.
module slcp_line_ctrl
   import slcp_pkg::*;
(
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step,
   input  logic [7:0]                       rx_byte,
   input  logic [VAL_W-1:0]                 led_count,
   input  logic [NUM_KEYS-1:0]              key_seen,
   input  logic [NUM_KEYS-1:0][VAL_W-1:0]   key_acc,
   output slcp_ctrl_type                    ctrl,
   output logic                             emit,
   output slcp_cmd_type                     cmd
);

   logic [LEN_W-1:0] len_ff, len_in;
   logic             cut_ff, cut_in;
   logic             z_ff, z_in;
   slcp_cmd_type     kept_ff, kept_in;
   logic             line_end;

   assign line_end = (rx_byte == CHAR_NEWLINE) || (len_ff == LEN_W'(LINE_BYTES - 1));

   // A zero byte cuts the line before it is scanned itself.
   assign ctrl.clear = step && line_end;
   assign ctrl.scan  = step && !line_end && !cut_ff && (rx_byte != CHAR_NUL);

   always_comb begin
      len_in  = len_ff;
      cut_in  = cut_ff;
      z_in    = z_ff;
      kept_in = kept_ff;
      if (ctrl.clear) begin
         len_in = '0;
         cut_in = 1'b0;
         z_in   = 1'b0;
         if (key_seen[KEY_MODE]) begin
            kept_in.mode = (key_acc[KEY_MODE] <= VAL_W'(9)) ? key_acc[KEY_MODE][3:0] : '0;
         end
         if (key_seen[KEY_RED]) begin
            kept_in.red = (key_acc[KEY_RED] <= VAL_W'(255)) ? key_acc[KEY_RED][7:0] : '0;
         end
         if (key_seen[KEY_GREEN]) begin
            kept_in.green = (key_acc[KEY_GREEN] <= VAL_W'(255)) ? key_acc[KEY_GREEN][7:0] : '0;
         end
         if (key_seen[KEY_BLUE]) begin
            kept_in.blue = (key_acc[KEY_BLUE] <= VAL_W'(255)) ? key_acc[KEY_BLUE][7:0] : '0;
         end
         if (key_seen[KEY_FIRST]) begin
            kept_in.first_led = (key_acc[KEY_FIRST] <= led_count) ? key_acc[KEY_FIRST] : '0;
         end
         if (key_seen[KEY_LAST]) begin
            kept_in.last_led = (key_acc[KEY_LAST] <= led_count) ? key_acc[KEY_LAST] : '0;
         end
         if (key_seen[KEY_STEP]) begin
            kept_in.led_step = (key_acc[KEY_STEP] <= led_count) ? key_acc[KEY_STEP] : '0;
         end
      end else if (step) begin
         len_in = len_ff + LEN_W'(1);
         if (rx_byte == CHAR_NUL) begin
            cut_in = 1'b1;
         end
         if (ctrl.scan && (rx_byte == CHAR_Z)) begin
            z_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff            <= '0;
         cut_ff            <= 1'b0;
         z_ff              <= 1'b0;
         kept_ff.mode      <= '0;
         kept_ff.red       <= '0;
         kept_ff.green     <= '0;
         kept_ff.blue      <= '0;
         kept_ff.first_led <= '0;
         kept_ff.last_led  <= LED_COUNT_RESET;
         kept_ff.led_step  <= STEP_RESET;
      end else begin
         len_ff  <= len_in;
         cut_ff  <= cut_in;
         z_ff    <= z_in;
         kept_ff <= kept_in;
      end
   end

   assign emit = ctrl.clear && z_ff;
   assign cmd  = kept_in;

endmodule

// ===== sv/serial_led_command_parser_unit.sv =====
// Top level of the serial LED command parser: request and response registers, CSR.
//
// Usage: received characters enter on the req_ channel, one per request
// (req_rx_byte). Bytes are framed into lines ending at a newline or at the
// 64th byte, which is dropped. Keys m, r, g, b, f, l and i set the kept
// command values; a line that contained 'z' produces one response on the
// rsp_ channel carrying all seven kept values after that line's updates.
// Lines without 'z' produce no response.
// A request is parsed while it sits in the input register; its response,
// if any, is loaded into the response register when that request advances.
// Throughput: one request per cycle while no response waits on rsp_ready; the
// key trackers (shift-and-add multiply by ten each) sit between the registers.
// Stall: while a response waits on rsp_ready, the input register holds and
// req_ready drops once it is full; nothing is lost.
// csr_led_count bounds first, last and step; write it only while idle.
// Reset (synchronous) empties both registers, clears the line state and
// restores led_count 150, last 150, step 1 and the other values to zero.
module serial_led_command_parser_unit
   import slcp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_rx_byte,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [3:0]       rsp_mode,
   output logic [7:0]       rsp_red,
   output logic [7:0]       rsp_green,
   output logic [7:0]       rsp_blue,
   output logic [VAL_W-1:0] rsp_first_led,
   output logic [VAL_W-1:0] rsp_last_led,
   output logic [VAL_W-1:0] rsp_led_step,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [VAL_W-1:0] csr_led_count
);

   logic [VAL_W-1:0] led_count_ff;
   logic             in_valid_ff;
   logic [7:0]       in_byte_ff;
   logic             out_valid_ff;
   slcp_cmd_type     out_cmd_ff;
   logic             step;
   slcp_ctrl_type    ctrl;
   logic             emit;
   slcp_cmd_type     cmd;

   logic [NUM_KEYS-1:0]            key_seen;
   logic [NUM_KEYS-1:0][VAL_W-1:0] key_acc;

   // The held request advances whenever the response register can take a result.
   assign step      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         led_count_ff <= LED_COUNT_RESET;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            led_count_ff <= csr_led_count;
         end
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (step) begin
            out_valid_ff <= emit;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_byte_ff <= req_rx_byte;
      end
      if (step && emit) begin
         out_cmd_ff <= cmd;
      end
   end

   slcp_line_ctrl u_line (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .rx_byte   (in_byte_ff),
      .led_count (led_count_ff),
      .key_seen  (key_seen),
      .key_acc   (key_acc),
      .ctrl      (ctrl),
      .emit      (emit),
      .cmd       (cmd)
   );

   for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
      localparam logic [7:0]       KeyCode = key_char(k);
      localparam logic [POS_W-1:0] KeyLim  = (k == KEY_MODE) ? WINDOW_ONE : WINDOW_THREE;

      slcp_key_track u_track (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .rx_byte    (in_byte_ff),
         .key_code   (KeyCode),
         .window_lim (KeyLim),
         .seen       (key_seen[k]),
         .acc        (key_acc[k])
      );
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_mode      = out_cmd_ff.mode;
   assign rsp_red       = out_cmd_ff.red;
   assign rsp_green     = out_cmd_ff.green;
   assign rsp_blue      = out_cmd_ff.blue;
   assign rsp_first_led = out_cmd_ff.first_led;
   assign rsp_last_led  = out_cmd_ff.last_led;
   assign rsp_led_step  = out_cmd_ff.led_step;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the serial LED command parser unit.
module tb_top;
   import slcp_pkg::*;

   localparam int IDLE_PCT      = 14;
   localparam int STALL_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 8;
   localparam int RANDOM_BYTES  = 600;
   localparam int PHASES        = 4;
   localparam int Z_SEEN        = 7;
   localparam int FIRST_DIGIT   = 2;
   localparam logic [7:0] FILL_CHAR  = 8'h2E;  // '.'
   localparam logic [7:0] SPACE_CHAR = 8'h20;

   typedef struct {
      string        text;
      int           nul_at;
      int           fill;
      bit           typed;
      slcp_cmd_type want;
   } line_row_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   logic [7:0]       req_rx_byte;
   logic             rsp_valid;
   logic             rsp_ready;
   logic [3:0]       rsp_mode;
   logic [7:0]       rsp_red;
   logic [7:0]       rsp_green;
   logic [7:0]       rsp_blue;
   logic [VAL_W-1:0] rsp_first_led;
   logic [VAL_W-1:0] rsp_last_led;
   logic [VAL_W-1:0] rsp_led_step;
   logic             csr_valid;
   logic             csr_ready;
   logic [VAL_W-1:0] csr_led_count;

   // Shadow copy of the parser state.
   int unsigned      line_fill;
   bit               line_cut;
   logic [7:0]       keys_seen;
   logic [POS_W-1:0] win_pos [NUM_KEYS];
   logic [VAL_W-1:0] digit_sum [NUM_KEYS];
   slcp_cmd_type     kept_cmd;
   logic [VAL_W-1:0] led_limit;

   slcp_cmd_type     pending_cmds [$];
   line_row_type     line_table [$];
   int               mismatch_count;
   int               quiet_cycles;
   bit               calm;

   serial_led_command_parser_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_rx_byte   (req_rx_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_mode      (rsp_mode),
      .rsp_red       (rsp_red),
      .rsp_green     (rsp_green),
      .rsp_blue      (rsp_blue),
      .rsp_first_led (rsp_first_led),
      .rsp_last_led  (rsp_last_led),
      .rsp_led_step  (rsp_led_step),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_led_count (csr_led_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] key_code(input int k);
      logic [7:0] c;
      case (k)
         KEY_MODE:  c = "m";
         KEY_RED:   c = "r";
         KEY_GREEN: c = "g";
         KEY_BLUE:  c = "b";
         KEY_FIRST: c = "f";
         KEY_LAST:  c = "l";
         default:   c = "i";
      endcase
      return c;
   endfunction

   function automatic logic [VAL_W-1:0] in_bound(input logic [VAL_W-1:0] v,
                                                 input logic [VAL_W-1:0] hi);
      return (v <= hi) ? v : '0;
   endfunction

   function automatic slcp_cmd_type make_cmd(input int m, input int r, input int g,
                                             input int b, input int f, input int l,
                                             input int i);
      slcp_cmd_type c;
      c.mode      = 4'(m);
      c.red       = 8'(r);
      c.green     = 8'(g);
      c.blue      = 8'(b);
      c.first_led = VAL_W'(f);
      c.last_led  = VAL_W'(l);
      c.led_step  = VAL_W'(i);
      return c;
   endfunction

   // Advances the shadow parser by one byte; returns 1 when a line with 'z' closes.
   function automatic bit parse_rx_byte(input logic [7:0] c, output slcp_cmd_type cmd);
      bit               fired;
      logic [POS_W-1:0] window_end;
      fired = 1'b0;
      cmd   = '0;
      if (c == CHAR_NEWLINE || line_fill + 1 >= LINE_BYTES) begin
         if (keys_seen[KEY_MODE])
            kept_cmd.mode  = 4'(in_bound(digit_sum[KEY_MODE], VAL_W'(9)));
         if (keys_seen[KEY_RED])
            kept_cmd.red   = 8'(in_bound(digit_sum[KEY_RED], VAL_W'(255)));
         if (keys_seen[KEY_GREEN])
            kept_cmd.green = 8'(in_bound(digit_sum[KEY_GREEN], VAL_W'(255)));
         if (keys_seen[KEY_BLUE])
            kept_cmd.blue  = 8'(in_bound(digit_sum[KEY_BLUE], VAL_W'(255)));
         if (keys_seen[KEY_FIRST])
            kept_cmd.first_led = in_bound(digit_sum[KEY_FIRST], led_limit);
         if (keys_seen[KEY_LAST])
            kept_cmd.last_led = in_bound(digit_sum[KEY_LAST], led_limit);
         if (keys_seen[KEY_STEP])
            kept_cmd.led_step = in_bound(digit_sum[KEY_STEP], led_limit);
         if (keys_seen[Z_SEEN]) begin
            cmd   = kept_cmd;
            fired = 1'b1;
         end
         line_fill = 0;
         line_cut  = 1'b0;
         keys_seen = '0;
         for (int k = 0; k < NUM_KEYS; k++) begin
            win_pos[k]   = '0;
            digit_sum[k] = '0;
         end
      end else begin
         line_fill++;
         if (c == CHAR_NUL)
            line_cut = 1'b1;
         if (!line_cut) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
               window_end = (k == KEY_MODE) ? WINDOW_ONE : WINDOW_THREE;
               if (keys_seen[k] && win_pos[k] < window_end) begin
                  win_pos[k]++;
                  if (win_pos[k] >= FIRST_DIGIT && c >= CHAR_ZERO && c <= CHAR_NINE)
                     digit_sum[k] = VAL_W'(digit_sum[k] * 10 + (c - CHAR_ZERO));
               end
            end
            // A key opens its window only on its first appearance in the line.
            for (int k = 0; k < NUM_KEYS; k++) begin
               if (c == key_code(k) && !keys_seen[k]) begin
                  keys_seen[k] = 1'b1;
                  win_pos[k]   = '0;
                  digit_sum[k] = '0;
               end
            end
            if (c == CHAR_Z)
               keys_seen[Z_SEEN] = 1'b1;
         end
      end
      return fired;
   endfunction

   function automatic int pick_value(input int k);
      int v;
      if (k == KEY_MODE)
         return int'($urandom_range(0, 9));
      case ($urandom_range(0, 5))
         0:       v = 0;
         1:       v = 255;
         2:       v = 256;
         3:       v = int'(led_limit);
         4:       v = int'(led_limit) + 1;
         default: v = int'($urandom_range(0, 999));
      endcase
      return (v > 999) ? 999 : v;
   endfunction

   task automatic send_byte(input logic [7:0] b, output bit fired, output slcp_cmd_type cmd);
      if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         do
            @(posedge clock);
         while ($urandom_range(0, 99) < IDLE_PCT);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do
         @(posedge clock);
      while (!req_ready);
      fired = parse_rx_byte(b, cmd);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_cmds.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_led_count(input logic [VAL_W-1:0] v);
      csr_valid     <= 1'b1;
      csr_led_count <= v;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      led_limit = v;
   endtask

   task automatic send_random_line(output int sent);
      logic [7:0]   line_q [$];
      string        num;
      int           k;
      bit           fired;
      slcp_cmd_type cmd;
      if ($urandom_range(0, 99) < 8) begin
         repeat ($urandom_range(1, 70)) line_q.push_back(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(1, 7)) begin
            k = $urandom_range(0, NUM_KEYS);
            if (k == NUM_KEYS) begin
               line_q.push_back(8'($urandom_range(1, 255)));
            end else begin
               line_q.push_back(key_code(k));
               line_q.push_back(($urandom_range(0, 3) == 0) ?
                                8'($urandom_range(1, 255)) : SPACE_CHAR);
               if ($urandom_range(0, 3) == 0)
                  num = $sformatf("%03d", pick_value(k));
               else
                  num = $sformatf("%0d", pick_value(k));
               for (int i = 0; i < num.len(); i++)
                  line_q.push_back(num[i]);
            end
         end
         if ($urandom_range(0, 99) < 85)
            line_q.insert($urandom_range(0, line_q.size()), CHAR_Z);
         if ($urandom_range(0, 99) < 5)
            line_q.insert($urandom_range(0, line_q.size()), CHAR_NUL);
      end
      // Some lines run to the length limit instead of ending at a newline.
      if ($urandom_range(0, 99) < 8) begin
         while (line_q.size() < LINE_BYTES)
            line_q.push_back(8'($urandom_range(0, 255)));
      end else begin
         line_q.push_back(CHAR_NEWLINE);
      end
      foreach (line_q[i]) begin
         send_byte(line_q[i], fired, cmd);
         if (fired)
            pending_cmds.push_back(cmd);
      end
      sent = line_q.size();
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      slcp_cmd_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_cmds.size() == 0) begin
            $display("%0t: expected no command, got mode %0d red %0d green %0d blue %0d",
                     $time, rsp_mode, rsp_red, rsp_green, rsp_blue);
            mismatch_count++;
         end else begin
            want = pending_cmds.pop_front();
            check_field("mode", want.mode, rsp_mode);
            check_field("red", want.red, rsp_red);
            check_field("green", want.green, rsp_green);
            check_field("blue", want.blue, rsp_blue);
            check_field("first_led", want.first_led, rsp_first_led);
            check_field("last_led", want.last_led, rsp_last_led);
            check_field("led_step", want.led_step, rsp_led_step);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      bit           fired;
      slcp_cmd_type cmd;
      logic [7:0]   b;
      int           phase_bytes;
      int           line_bytes;
      logic [VAL_W-1:0] phase_limit [PHASES];

      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_rx_byte   <= '0;
      csr_valid     <= 1'b0;
      csr_led_count <= '0;
      mismatch_count = 0;
      quiet_cycles   = 0;
      calm           = 1'b0;
      led_limit      = LED_COUNT_RESET;
      kept_cmd       = make_cmd(0, 0, 0, 0, 0, int'(LED_COUNT_RESET), int'(STEP_RESET));
      line_fill      = 0;
      line_cut       = 1'b0;
      keys_seen      = '0;
      for (int k = 0; k < NUM_KEYS; k++) begin
         win_pos[k]   = '0;
         digit_sum[k] = '0;
      end

      line_table = '{
         '{"z\n", -1, 0, 1'b1, make_cmd(0, 0, 0, 0, 0, 150, 1)},
         '{"zm 9r 255g 255b 255f 150l 150i 150\n", -1, 0, 1'b1,
           make_cmd(9, 255, 255, 255, 150, 150, 150)},
         '{"zm 10r 256g 999b 300f 151l 999i 151\n", -1, 0, 1'b1,
           make_cmd(1, 0, 0, 0, 0, 0, 0)},
         '{"zm 0r 000g 0b 0f 0l 0i 0\n", -1, 0, 1'b1, make_cmd(0, 0, 0, 0, 0, 0, 0)},
         '{"m 3r 1r 2\n", -1, 0, 1'b0, '0},
         '{"z\n", -1, 0, 1'b0, '0},
         '{"zr 1_5\n", 4, 0, 1'b0, '0},
         '{"zm 4_", 4, 59, 1'b0, '0},
         '{"zg 7", -1, 60, 1'b0, '0},
         '{"zb\n", -1, 0, 1'b0, '0},
         '{"zf 1\n", -1, 0, 1'b0, '0},
         '{"z\377r 7\200\n", -1, 0, 1'b0, '0},
         '{"ri12z\n", -1, 0, 1'b0, '0},
         '{"mzz9\n", -1, 0, 1'b0, '0},
         '{"\n", -1, 0, 1'b0, '0},
         '{"l 9x\n", -1, 0, 1'b0, '0},
         '{"zi 0\n", -1, 0, 1'b0, '0},
         '{"", -1, 64, 1'b0, '0},
         '{"z m 5 r 9 9 9\n", -1, 0, 1'b0, '0},
         '{"\001\002\004\010\020\040\100z\n", -1, 0, 1'b0, '0}
      };

      phase_limit[0] = 10'd1;
      phase_limit[1] = 10'd999;
      phase_limit[2] = VAL_W'($urandom_range(2, 998));
      phase_limit[3] = LED_COUNT_RESET;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (line_table[r]) begin
         for (int i = 0; i < line_table[r].text.len() + line_table[r].fill; i++) begin
            if (i >= line_table[r].text.len())
               b = FILL_CHAR;
            else if (i == line_table[r].nul_at)
               b = CHAR_NUL;
            else
               b = line_table[r].text[i];
            send_byte(b, fired, cmd);
            if (fired)
               pending_cmds.push_back(line_table[r].typed ? line_table[r].want : cmd);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         // The parser must be idle before its bound changes.
         wait_idle();
         write_led_count(phase_limit[p]);
         calm        = (p == 2);
         phase_bytes = 0;
         while (phase_bytes < RANDOM_BYTES / PHASES) begin
            send_random_line(line_bytes);
            phase_bytes = phase_bytes + line_bytes;
         end
      end
      calm = 1'b0;

      wait_idle();
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== files.f =====
sv/slcp_pkg.sv
sv/slcp_key_track.sv
sv/slcp_line_ctrl.sv
sv/serial_led_command_parser_unit.sv
bench/tb_top.sv
